FILE: rtl/core/lsl_pkg.sv
// Shared constants and types of the lottery scheduler with its congruential draw.
package lsl_pkg;

    // Generator word and its recurrence seed = seed * LCG_MUL + LCG_INC.
    localparam int unsigned SEED_W = 32;
    localparam logic [SEED_W-1:0] LCG_MUL = 32'd2719;
    localparam logic [SEED_W-1:0] LCG_INC = 32'd5813;
    localparam logic [SEED_W-1:0] SEED_RESET = 32'd5813;

    // Bits of the multiplier constant walked by the serial multiply.
    localparam int unsigned MUL_W = $clog2(2719 + 1);

    // Bit counter of the serial remainder, one quotient bit per cycle.
    localparam int unsigned DIV_CNT_W = $clog2(SEED_W);

    // Fixed port widths.
    localparam int unsigned SLOT_W = 6;
    localparam int unsigned TICKET_PORT_W = 16;
    localparam int unsigned DRAW_W = 22;
    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;

    // Default sizing of the scheduler.
    localparam int unsigned DEF_SLOTS = 64;
    localparam int unsigned DEF_TICKET_BITS = 16;

    // Status returned by the draw unit.
    typedef struct packed {
        logic done;
        logic zero_total;
    } t_draw_stat;

endpackage

FILE: rtl/core/lsl_draw.sv
// Draw unit: bit-serial generator step followed by a bit-serial remainder.
module lsl_draw #(
    parameter int unsigned TOTAL_W = 22
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_go,
    input  logic [lsl_pkg::SEED_W-1:0] i_seed,
    input  logic [TOTAL_W-1:0]         i_total,
    output lsl_pkg::t_draw_stat        o_stat,
    output logic [lsl_pkg::SEED_W-1:0] o_seed,
    output logic [TOTAL_W-1:0]         o_draw
);

    localparam int unsigned SW = lsl_pkg::SEED_W;
    localparam int unsigned MW = lsl_pkg::MUL_W;
    localparam int unsigned CW = lsl_pkg::DIV_CNT_W;

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_MUL  = 2'd1;
    localparam logic [1:0] D_DIV  = 2'd2;

    logic [1:0]         r_state;
    logic [MW-1:0]      r_k;
    logic [SW-1:0]      r_m;
    logic [SW-1:0]      r_acc;
    logic [SW-1:0]      r_q;
    logic [TOTAL_W-1:0] r_rem;
    logic [CW-1:0]      r_cnt;
    logic [SW-1:0]      r_seed_o;
    logic               r_done;
    logic               r_zero;

    logic [SW-1:0]      n_acc;
    logic [SW-1:0]      n_seed;
    logic [TOTAL_W:0]   n_trial;
    logic [TOTAL_W-1:0] n_rem;

    // One multiplier bit per cycle, then the increment; one remainder bit per cycle.
    always_comb begin
        n_acc = r_acc + (r_k[0] ? r_m : '0);
        n_seed = n_acc + lsl_pkg::LCG_INC;
        n_trial = {r_rem, r_q[SW-1]};
        if (n_trial >= {1'b0, i_total}) begin
            n_rem = TOTAL_W'(n_trial - {1'b0, i_total});
        end else begin
            n_rem = n_trial[TOTAL_W-1:0];
        end
    end

    // Sequencer of the draw.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
            r_zero  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                D_IDLE: begin
                    if (i_go) begin
                        r_k     <= lsl_pkg::LCG_MUL[MW-1:0];
                        r_m     <= i_seed;
                        r_acc   <= '0;
                        r_state <= D_MUL;
                    end
                end
                D_MUL: begin
                    r_acc <= n_acc;
                    r_m   <= {r_m[SW-2:0], 1'b0};
                    r_k   <= {1'b0, r_k[MW-1:1]};
                    if (r_k[MW-1:1] == '0) begin
                        r_seed_o <= n_seed;
                        if (i_total == '0) begin
                            r_done  <= 1'b1;
                            r_zero  <= 1'b1;
                            r_state <= D_IDLE;
                        end else begin
                            r_q     <= n_seed;
                            r_rem   <= '0;
                            r_cnt   <= '0;
                            r_state <= D_DIV;
                        end
                    end
                end
                D_DIV: begin
                    r_rem <= n_rem;
                    r_q   <= {r_q[SW-2:0], 1'b0};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(SW - 1)) begin
                        r_done  <= 1'b1;
                        r_zero  <= 1'b0;
                        r_state <= D_IDLE;
                    end
                end
                default: begin
                    r_state <= D_IDLE;
                end
            endcase
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.zero_total = r_zero;
    assign o_seed = r_seed_o;
    assign o_draw = r_rem;

endmodule

FILE: rtl/core/lottery_scheduler_lcg.sv
// Top level of the lottery scheduler: slot store, round bookkeeping and winner walk.
//
//  channel   direction  handshake                  payload
//  load      in         start high, busy low       i_slot_index i_tickets i_counted
//                                                  i_runnable i_last
//  result    out        o_done, one cycle          o_grant_valid o_grant_index o_idle
//                                                  o_zero_total o_draw
//  config    in/out     psel penable pwrite pready paddr pwdata prdata
//
// A load word that does not end the round reads the slot store, then writes it with the
// round total and runnable count corrected in the same cycle.
// A word with i_last set adds the draw: the serial generator step, then the serial
// remainder, then a sweep through the slot store that finds the winner and clears the
// round; the draw is skipped when no slot is runnable, the remainder when the total is zero.
// After reset the same sweep clears the round marks while busy stays high;
// configuration writes are taken throughout.
// Results are shown for one cycle on o_done and cannot be held off by the receiver.
module lottery_scheduler_lcg #(
    parameter int unsigned SLOTS = lsl_pkg::DEF_SLOTS,
    parameter int unsigned TICKET_BITS = lsl_pkg::DEF_TICKET_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [lsl_pkg::SLOT_W-1:0]          i_slot_index,
    input  logic [lsl_pkg::TICKET_PORT_W-1:0]   i_tickets,
    input  logic                                i_counted,
    input  logic                                i_runnable,
    input  logic                                i_last,
    output logic                                o_done,
    output logic                                o_grant_valid,
    output logic [lsl_pkg::SLOT_W-1:0]          o_grant_index,
    output logic                                o_idle,
    output logic                                o_zero_total,
    output logic [lsl_pkg::DRAW_W-1:0]          o_draw,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lsl_pkg::PADDR_W-1:0]         paddr,
    input  logic [lsl_pkg::PDATA_W-1:0]         pwdata,
    output logic [lsl_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready
);

    localparam int unsigned IDX_W = $clog2(SLOTS);
    localparam int unsigned CNT_W = $clog2(SLOTS + 1);
    localparam int unsigned TOTAL_W = TICKET_BITS + IDX_W;
    localparam int unsigned SW = lsl_pkg::SEED_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_DRAW  = 3'd2;
    localparam logic [2:0] S_WAIT  = 3'd3;
    localparam logic [2:0] S_SWEEP = 3'd4;

    localparam logic REG_SEED_INIT = 1'b0;

    // Control state.
    logic [2:0]             r_state;
    logic [CNT_W-1:0]       r_sw_cnt;
    logic                   r_pv;
    logic                   r_emit;
    logic                   r_f_idle;
    logic                   r_f_zero;
    logic                   r_found;
    logic [TOTAL_W-1:0]     r_total;
    logic [CNT_W-1:0]       r_runs;
    logic [SW-1:0]          r_seed;
    logic [SW-1:0]          r_seed_init;
    logic                   r_go;
    logic                   r_done;

    // Payload registers.
    logic                   r_in_ok;
    logic [IDX_W-1:0]       r_addr;
    logic [TICKET_BITS-1:0] r_tk_new;
    logic                   r_run_new;
    logic                   r_last;
    logic [IDX_W-1:0]       r_pidx;
    logic [TOTAL_W-1:0]     r_sum;
    logic                   r_gv;
    logic [IDX_W-1:0]       r_gidx;
    logic                   r_o_gv;
    logic [lsl_pkg::SLOT_W-1:0] r_o_gidx;
    logic                   r_o_idle;
    logic                   r_o_zero;
    logic [lsl_pkg::DRAW_W-1:0] r_o_draw;

    // Slot store: tickets with the runnable bit, and the round marks.
    logic [TICKET_BITS:0]   tk_mem [SLOTS];
    logic                   ld_mem [SLOTS];
    logic [TICKET_BITS:0]   r_tk_rd;
    logic                   r_ld_rd;

    logic [15:0]            slot_wide;
    logic                   slot_ok;
    logic [IDX_W-1:0]       rd_addr;
    logic                   tk_we;
    logic                   ld_we;
    logic [IDX_W-1:0]       wr_addr;
    logic                   ld_wd;
    logic                   accept;
    logic                   cfg_wr;
    logic [31:0]            tk_in_wide;

    logic [TICKET_BITS-1:0] old_tk;
    logic                   old_run;
    logic [TOTAL_W-1:0]     n_total;
    logic [CNT_W-1:0]       n_runs;

    logic                   walk_en;
    logic [TOTAL_W-1:0]     walk_sum;
    logic                   n_found;
    logic                   n_gv;
    logic [IDX_W-1:0]       n_gidx;
    logic [TOTAL_W-1:0]     n_sum;
    logic [15:0]            gidx_wide;
    logic [63:0]            draw_wide;

    lsl_pkg::t_draw_stat    draw_stat;
    logic [SW-1:0]          draw_seed;
    logic [TOTAL_W-1:0]     draw_val;

    assign accept = start && !busy;
    assign busy = (r_state != S_IDLE);
    assign cfg_wr = psel && penable && pwrite;
    assign slot_wide = 16'(i_slot_index);
    assign slot_ok = (slot_wide < 16'(SLOTS));
    assign tk_in_wide = 32'(i_tickets);

    // Store port selection: loads use the slot, the sweep walks every entry.
    always_comb begin
        rd_addr = slot_wide[IDX_W-1:0];
        tk_we = 1'b0;
        ld_we = 1'b0;
        wr_addr = r_addr;
        ld_wd = 1'b1;
        if (r_state == S_SWEEP) begin
            rd_addr = r_sw_cnt[IDX_W-1:0];
            wr_addr = r_sw_cnt[IDX_W-1:0];
            ld_wd = 1'b0;
            ld_we = (r_sw_cnt < CNT_W'(SLOTS));
        end else if (r_state == S_LOAD) begin
            tk_we = r_in_ok;
            ld_we = r_in_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tk_we) begin
            tk_mem[wr_addr] <= {r_run_new, r_tk_new};
        end
        if (ld_we) begin
            ld_mem[wr_addr] <= ld_wd;
        end
        r_tk_rd <= tk_mem[rd_addr];
        r_ld_rd <= ld_mem[rd_addr];
    end

    // Round total and runnable count with the earlier entry of the slot taken out and the new one put in.
    always_comb begin
        old_tk = r_ld_rd ? r_tk_rd[TICKET_BITS-1:0] : '0;
        old_run = r_ld_rd && r_tk_rd[TICKET_BITS];
        n_total = r_total - TOTAL_W'(old_tk) + TOTAL_W'(r_tk_new);
        n_runs = r_runs - CNT_W'(old_run) + CNT_W'(r_run_new);
    end

    // Winner walk: running ticket sum over the marked entries in slot order.
    always_comb begin
        walk_en = !r_f_idle && !r_f_zero;
        walk_sum = r_sum + TOTAL_W'(r_tk_rd[TICKET_BITS-1:0]);
        n_found = r_found;
        n_gv = r_gv;
        n_gidx = r_gidx;
        n_sum = r_sum;
        if (r_pv && r_ld_rd && walk_en && !r_found) begin
            n_sum = walk_sum;
            if (walk_sum > draw_val) begin
                n_found = 1'b1;
                n_gv = r_tk_rd[TICKET_BITS];
                n_gidx = r_tk_rd[TICKET_BITS] ? r_pidx : '0;
            end
        end
        gidx_wide = 16'(n_gidx);
        draw_wide = walk_en ? 64'(draw_val) : '0;
    end

    // Draw unit: generator step and remainder.
    lsl_draw #(
        .TOTAL_W (TOTAL_W)
    ) u_draw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (r_go),
        .i_seed  (r_seed),
        .i_total (r_total),
        .o_stat  (draw_stat),
        .o_seed  (draw_seed),
        .o_draw  (draw_val)
    );

    // Main sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_sw_cnt    <= '0;
            r_pv        <= 1'b0;
            r_emit      <= 1'b0;
            r_f_idle    <= 1'b0;
            r_f_zero    <= 1'b0;
            r_found     <= 1'b0;
            r_total     <= '0;
            r_runs      <= '0;
            r_seed      <= lsl_pkg::SEED_RESET;
            r_seed_init <= lsl_pkg::SEED_RESET;
            r_go        <= 1'b0;
            r_done      <= 1'b0;
        end else begin
            r_go   <= 1'b0;
            r_done <= 1'b0;

            // Seed register write from the configuration port.
            if (cfg_wr && (paddr[2] == REG_SEED_INIT)) begin
                r_seed_init <= pwdata;
                r_seed      <= pwdata;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_in_ok   <= slot_ok;
                        r_addr    <= slot_wide[IDX_W-1:0];
                        r_tk_new  <= i_counted ? tk_in_wide[TICKET_BITS-1:0] : '0;
                        r_run_new <= i_counted && i_runnable;
                        r_last    <= i_last;
                        r_state   <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    if (r_in_ok) begin
                        r_total <= n_total;
                        r_runs  <= n_runs;
                    end
                    r_state <= r_last ? S_DRAW : S_IDLE;
                end
                S_DRAW: begin
                    if (r_runs == '0) begin
                        r_f_idle <= 1'b1;
                        r_f_zero <= 1'b0;
                        r_emit   <= 1'b1;
                        r_sw_cnt <= '0;
                        r_pv     <= 1'b0;
                        r_found  <= 1'b0;
                        r_sum    <= '0;
                        r_gv     <= 1'b0;
                        r_gidx   <= '0;
                        r_state  <= S_SWEEP;
                    end else begin
                        r_go    <= 1'b1;
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (draw_stat.done) begin
                        r_seed   <= draw_seed;
                        r_f_idle <= 1'b0;
                        r_f_zero <= draw_stat.zero_total;
                        r_emit   <= 1'b1;
                        r_sw_cnt <= '0;
                        r_pv     <= 1'b0;
                        r_found  <= 1'b0;
                        r_sum    <= '0;
                        r_gv     <= 1'b0;
                        r_gidx   <= '0;
                        r_state  <= S_SWEEP;
                    end
                end
                S_SWEEP: begin
                    r_found <= n_found;
                    r_sum   <= n_sum;
                    r_gv    <= n_gv;
                    r_gidx  <= n_gidx;
                    r_pidx  <= r_sw_cnt[IDX_W-1:0];
                    if (r_sw_cnt < CNT_W'(SLOTS)) begin
                        r_pv     <= 1'b1;
                        r_sw_cnt <= r_sw_cnt + 1'b1;
                    end else begin
                        r_pv     <= 1'b0;
                        r_total  <= '0;
                        r_runs   <= '0;
                        r_done   <= r_emit;
                        r_emit   <= 1'b0;
                        r_o_gv   <= n_gv;
                        r_o_gidx <= gidx_wide[lsl_pkg::SLOT_W-1:0];
                        r_o_idle <= r_f_idle;
                        r_o_zero <= r_f_zero;
                        r_o_draw <= draw_wide[lsl_pkg::DRAW_W-1:0];
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Result word and configuration read-back.
    assign o_done = r_done;
    assign o_grant_valid = r_o_gv;
    assign o_grant_index = r_o_gidx;
    assign o_idle = r_o_idle;
    assign o_zero_total = r_o_zero;
    assign o_draw = r_o_draw;
    assign prdata = (paddr[2] == REG_SEED_INIT) ? r_seed_init : '0;
    assign pready = 1'b1;

endmodule
